// ===== rtl/artc_pkg.sv =====
// ----------------------------------------------------------------------------
// artc_pkg
// Shared types and constants of the retransmit controller: transaction field
// widths, kind codes, phase and parser position types, register map.
// ----------------------------------------------------------------------------
package artc_pkg;

    // transaction field widths
    localparam int KIND_W    = 2;
    localparam int BYTE_W    = 8;
    localparam int TICKS_W   = 8;
    localparam int ADDR_W    = 16;
    localparam int PHASE_W   = 2;
    localparam int PADDR_W   = 4;
    localparam int PDATA_W   = 32;

    // input kinds
    localparam logic [KIND_W-1:0] KIND_TICK    = 2'd0;
    localparam logic [KIND_W-1:0] KIND_BYTE    = 2'd1;
    localparam logic [KIND_W-1:0] KIND_REQUEST = 2'd2;

    // frame markers
    localparam logic [BYTE_W-1:0] START_MARK = 8'h21;
    localparam logic [BYTE_W-1:0] END_MARK   = 8'h23;

    // register indexes, byte address is 4 * index
    localparam logic [1:0] REG_POWER_UP  = 2'd0;
    localparam logic [1:0] REG_ACK_WAIT  = 2'd1;
    localparam logic [1:0] REG_RETRY_LIM = 2'd2;
    localparam logic [1:0] REG_ACK_ADDR  = 2'd3;

    // register reset values
    localparam logic [TICKS_W-1:0] RST_POWER_UP  = 8'd2;
    localparam logic [TICKS_W-1:0] RST_ACK_WAIT  = 8'd20;
    localparam logic [TICKS_W-1:0] RST_RETRY_LIM = 8'd2;
    localparam logic [ADDR_W-1:0]  RST_ACK_ADDR  = 16'd1;

    // link phase
    typedef enum logic [PHASE_W-1:0] {
        PH_OFF   = 2'd0,
        PH_POWER = 2'd1,
        PH_SENT  = 2'd2,
        PH_WAIT  = 2'd3
    } t_phase;

    // frame parser position
    typedef enum logic [2:0] {
        POS_HUNT = 3'd0,
        POS_LO   = 3'd1,
        POS_HI   = 3'd2,
        POS_END  = 3'd3,
        POS_SUM  = 3'd4,
        POS_SKIP = 3'd5
    } t_parse_pos;

endpackage

// ===== rtl/artc_ifs.sv =====
// ----------------------------------------------------------------------------
// artc interfaces
// Valid/ready channels for input transactions and result transactions.
// ----------------------------------------------------------------------------
interface artc_in_if import artc_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [KIND_W-1:0] kind;
    logic [BYTE_W-1:0] rx_byte;
    logic              use_gps_frame;

    modport source (output valid, output kind, output rx_byte, output use_gps_frame,
                    input ready);
    modport sink   (input valid, input kind, input rx_byte, input use_gps_frame,
                    output ready);
endinterface

interface artc_out_if import artc_pkg::*; ();
    logic               valid;
    logic               ready;
    logic               radio_on;
    logic               start_transmit;
    logic               transmit_gps_frame;
    logic               done_acked;
    logic               done_failed;
    logic [PHASE_W-1:0] phase;

    modport source (output valid, output radio_on, output start_transmit,
                    output transmit_gps_frame, output done_acked, output done_failed,
                    output phase, input ready);
    modport sink   (input valid, input radio_on, input start_transmit,
                    input transmit_gps_frame, input done_acked, input done_failed,
                    input phase, output ready);
endinterface

// ===== rtl/ack_retry_transmit_controller.sv =====
// ----------------------------------------------------------------------------
// ack_retry_transmit_controller
// Stop-and-wait retransmission control for a radio link, with an ack frame
// parser on the received byte stream and an APB-style register port.
// ----------------------------------------------------------------------------
//  channel   direction  handshake          payload
//  i_in      in         valid/ready        kind, rx_byte, use_gps_frame
//  o_out     out        valid/ready        radio_on .. phase (one per input)
//  apb       in         psel/penable       power_up_ticks, ack_wait_ticks,
//                                          retry_limit, ack_address
//
// One transaction per cycle while the output is not stalled: an input register,
// then the state update and a result register that holds each result.
// Synchronous active-low reset clears state and loads the register defaults.
// A stalled output holds the result register and the input register; i_in is
// still taken while the input register is empty.
// ----------------------------------------------------------------------------
module ack_retry_transmit_controller import artc_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    artc_in_if.sink            i_in,
    artc_out_if.source         o_out,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready
);

    // configuration registers
    logic [TICKS_W-1:0] r_power_up;
    logic [TICKS_W-1:0] r_ack_wait;
    logic [TICKS_W-1:0] r_retry_lim;
    logic [ADDR_W-1:0]  r_ack_addr;
    logic               cfg_write;
    logic [1:0]         cfg_idx;

    assign pready    = 1'b1;
    assign cfg_idx   = paddr[3:2];
    assign cfg_write = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_power_up  <= RST_POWER_UP;
            r_ack_wait  <= RST_ACK_WAIT;
            r_retry_lim <= RST_RETRY_LIM;
            r_ack_addr  <= RST_ACK_ADDR;
        end else if (cfg_write) begin
            case (cfg_idx)
                REG_POWER_UP:  r_power_up  <= pwdata[TICKS_W-1:0];
                REG_ACK_WAIT:  r_ack_wait  <= pwdata[TICKS_W-1:0];
                REG_RETRY_LIM: r_retry_lim <= pwdata[TICKS_W-1:0];
                REG_ACK_ADDR:  r_ack_addr  <= pwdata[ADDR_W-1:0];
                default: ;
            endcase
        end
    end

    // register read back
    always_comb begin
        case (cfg_idx)
            REG_POWER_UP:  prdata = {{(PDATA_W-TICKS_W){1'b0}}, r_power_up};
            REG_ACK_WAIT:  prdata = {{(PDATA_W-TICKS_W){1'b0}}, r_ack_wait};
            REG_RETRY_LIM: prdata = {{(PDATA_W-TICKS_W){1'b0}}, r_retry_lim};
            REG_ACK_ADDR:  prdata = {{(PDATA_W-ADDR_W){1'b0}}, r_ack_addr};
            default:       prdata = '0;
        endcase
    end

    // pipeline handshake
    logic r_in_valid;
    logic r_out_valid;
    logic advance;
    logic in_ready;
    logic step;

    assign advance    = !r_out_valid || o_out.ready;
    assign in_ready   = !r_in_valid || advance;
    assign step       = advance && r_in_valid;
    assign i_in.ready = in_ready;

    // input register
    logic [KIND_W-1:0] r_kind;
    logic [BYTE_W-1:0] r_rx_byte;
    logic              r_gps;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_ready) begin
            r_in_valid <= i_in.valid;
        end
        if (in_ready && i_in.valid) begin
            r_kind    <= i_in.kind;
            r_rx_byte <= i_in.rx_byte;
            r_gps     <= i_in.use_gps_frame;
        end
    end

    // ack frame parser
    logic frame_ok;

    artc_parser u_parser (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_byte_valid  (step && (r_kind == KIND_BYTE)),
        .i_byte        (r_rx_byte),
        .i_ack_address (r_ack_addr),
        .o_frame_ok    (frame_ok)
    );

    // link state
    t_phase             r_phase, n_phase;
    logic [TICKS_W-1:0] r_ticks, n_ticks;
    logic [TICKS_W-1:0] r_retries, n_retries;
    logic               r_pending, n_pending;
    logic               r_type, n_type;
    logic               r_ack, n_ack;
    logic               n_tx, n_acked, n_failed;
    logic [TICKS_W-1:0] ticks_dec;

    assign ticks_dec = (r_ticks != '0) ? r_ticks - 1'b1 : r_ticks;

    // next state and pulses for the transaction in the input register
    always_comb begin
        n_phase   = r_phase;
        n_ticks   = r_ticks;
        n_retries = r_retries;
        n_pending = r_pending;
        n_type    = r_type;
        n_ack     = r_ack || frame_ok;
        n_tx      = 1'b0;
        n_acked   = 1'b0;
        n_failed  = 1'b0;
        if (r_kind == KIND_REQUEST) begin
            n_pending = 1'b1;
            n_type    = r_gps;
        end else if (r_kind == KIND_TICK) begin
            case (r_phase)
                PH_OFF: begin
                    if (r_pending) begin
                        n_phase   = PH_POWER;
                        n_ack     = 1'b0;
                        n_pending = 1'b0;
                        n_ticks   = r_power_up;
                    end
                end
                PH_POWER: begin
                    n_ticks = ticks_dec;
                    if (ticks_dec == '0) begin
                        n_phase   = PH_SENT;
                        n_retries = r_retry_lim;
                        n_tx      = 1'b1;
                    end
                end
                PH_SENT: begin
                    n_phase = PH_WAIT;
                    n_ticks = r_ack_wait;
                end
                default: begin
                    if (r_ack) begin
                        n_phase = PH_OFF;
                        n_acked = 1'b1;
                    end else begin
                        n_ticks = ticks_dec;
                        if (ticks_dec == '0) begin
                            if (r_retries != '0) begin
                                n_retries = r_retries - 1'b1;
                                n_phase   = PH_SENT;
                                n_tx      = 1'b1;
                            end else begin
                                n_phase  = PH_OFF;
                                n_failed = 1'b1;
                            end
                        end
                    end
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_OFF;
            r_ticks   <= '0;
            r_retries <= '0;
            r_pending <= 1'b0;
            r_type    <= 1'b0;
            r_ack     <= 1'b0;
        end else if (step) begin
            r_phase   <= n_phase;
            r_ticks   <= n_ticks;
            r_retries <= n_retries;
            r_pending <= n_pending;
            r_type    <= n_type;
            r_ack     <= n_ack;
        end
    end

    // result register
    logic               r_radio_on;
    logic               r_tx;
    logic               r_tx_gps;
    logic               r_acked;
    logic               r_failed;
    logic [PHASE_W-1:0] r_out_phase;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= r_in_valid;
        end
        if (step) begin
            r_radio_on  <= (n_phase != PH_OFF);
            r_tx        <= n_tx;
            r_tx_gps    <= n_tx && n_type;
            r_acked     <= n_acked;
            r_failed    <= n_failed;
            r_out_phase <= n_phase;
        end
    end

    assign o_out.valid              = r_out_valid;
    assign o_out.radio_on           = r_radio_on;
    assign o_out.start_transmit     = r_tx;
    assign o_out.transmit_gps_frame = r_tx_gps;
    assign o_out.done_acked         = r_acked;
    assign o_out.done_failed        = r_failed;
    assign o_out.phase              = r_out_phase;

endmodule

// ===== rtl/artc_parser.sv =====
// ----------------------------------------------------------------------------
// artc_parser
// Byte-wise frame parser: start marker, address low, address high, end
// marker, XOR checksum. Flags a good frame addressed to the ack address.
// ----------------------------------------------------------------------------
module artc_parser import artc_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_byte_valid,
    input  logic [BYTE_W-1:0] i_byte,
    input  logic [ADDR_W-1:0] i_ack_address,
    output logic              o_frame_ok
);

    t_parse_pos        r_pos, n_pos;
    logic [ADDR_W-1:0] r_addr, n_addr;
    logic [BYTE_W-1:0] r_xor, n_xor;

    // next parser state for the current byte
    always_comb begin
        n_pos      = r_pos;
        n_addr     = r_addr;
        n_xor      = r_xor;
        o_frame_ok = 1'b0;
        if (i_byte_valid) begin
            case (r_pos)
                POS_HUNT: begin
                    if (i_byte == START_MARK) begin
                        n_xor  = START_MARK;
                        n_addr = '0;
                        n_pos  = POS_LO;
                    end
                end
                POS_LO: begin
                    n_addr = {{(ADDR_W-BYTE_W){1'b0}}, i_byte};
                    n_xor  = r_xor ^ i_byte;
                    n_pos  = POS_HI;
                end
                POS_HI: begin
                    n_addr = {i_byte, r_addr[BYTE_W-1:0]};
                    n_xor  = r_xor ^ i_byte;
                    n_pos  = POS_END;
                end
                POS_END: begin
                    n_xor = r_xor ^ i_byte;
                    n_pos = (i_byte == END_MARK) ? POS_SUM : POS_SKIP;
                end
                POS_SUM: begin
                    o_frame_ok = (i_byte == r_xor) && (r_addr == i_ack_address);
                    n_pos      = POS_HUNT;
                end
                default: begin
                    n_pos = POS_HUNT;
                end
            endcase
        end
    end

    // position is control, address and checksum are payload
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos <= POS_HUNT;
        end else begin
            r_pos <= n_pos;
        end
        r_addr <= n_addr;
        r_xor  <= n_xor;
    end

endmodule
